[rtl/core/vca_bank_with_mix_macros.svh]
// ----------------------------------------------------------------------------
// vca_bank_with_mix assertion macros
// Concurrent assertion shorthands on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef VCA_BANK_WITH_MIX_MACROS_SVH
`define VCA_BANK_WITH_MIX_MACROS_SVH

// check cons in the cycle after ante
`define VCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check cons in the same cycle as ante
`define VCA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/vca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vca_pkg;

    localparam int EXP_TABLE_POINTS_DEFAULT = 33;

    localparam int DATA_W    = 16;
    localparam int MIX_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_TWO = 2'd2;

    localparam logic [15:0] GAIN_UNITY = 16'd32768;
    localparam logic [14:0] TEN_VOLTS  = 15'd20480;
    localparam logic [47:0] HALF_TEN   = 48'd10240;
    localparam logic [47:0] ROUND_Q15  = 48'd16384;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] LOG2_50_Q30 = 64'd6060044440;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] EXP_DEN_Q30 = 64'd49 << 30;
    localparam logic [63:0] Q15_ONE     = 64'd32768;
    localparam int          EXP_SERIES_TERMS = 14;

    localparam int          DIV_DIGIT_W = 8;
    localparam int          DIV_DIGITS  = 5;
    localparam int          DIV_W       = DIV_DIGIT_W * DIV_DIGITS;
    localparam logic [3:0]  DIVISOR     = 4'd5;

    typedef enum logic [2:0] {
        MUL_LEVEL,
        MUL_LIN,
        MUL_POS,
        MUL_INTERP,
        MUL_EXP,
        MUL_MIX1,
        MUL_MIX2
    } mul_sel_t;

    typedef enum logic [1:0] {
        M_SRC_LEVEL,
        M_SRC_DIV,
        M_SRC_EXP
    } m_src_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     div_round;
        logic     m_wb;
        m_src_t   m_src;
        logic     idx_wb;
        logic     tab_rd;
        logic     g_wb;
        logic     ch_wb;
        logic     acc_wb;
        logic     mix1_wb;
        logic     mix2_wb;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic lin_on;
        logic exp_on;
        logic last;
        logic div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/vca_div5.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_div5
// Iterative divide by five, one byte of dividend per cycle, MSB first.
// ----------------------------------------------------------------------------
module vca_div5 import vca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    output logic [DIV_W-1:0] quotient,
    output logic [2:0]       remainder,
    output logic             done
);

    localparam int CntW = $clog2(DIV_DIGITS + 1);

    logic [DIV_W-1:0]       num_reg;
    logic [2:0]             rem_reg;
    logic [CntW-1:0]        cnt_reg;
    logic                   done_reg;
    logic [DIV_DIGIT_W-1:0] qbyte;
    logic [2:0]             rem_next;

    always_comb
    begin
        logic [3:0] t;
        logic [2:0] r;
        r = rem_reg;
        qbyte = '0;
        for (int i = DIV_DIGIT_W - 1; i >= 0; i--)
        begin
            t = {r, num_reg[DIV_W-DIV_DIGIT_W+i]};
            if (t >= DIVISOR)
            begin
                qbyte[i] = 1'b1;
                r = 3'(t - DIVISOR);
            end
            else
            begin
                r = t[2:0];
            end
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CntW'(DIV_DIGITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CntW'(1);
            done_reg <= (cnt_reg == CntW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[DIV_W-DIV_DIGIT_W-1:0], qbyte};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = num_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

[rtl/core/vca_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_dp
// Datapath: shared multiplier, divide-by-five unit, gain table, mix bus.
// ----------------------------------------------------------------------------
module vca_dp import vca_pkg::*;
#(
    parameter int EXP_TABLE_POINTS = EXP_TABLE_POINTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DATA_W-1:0]    sample,
    input  logic [DATA_W-1:0]    lin_cv,
    input  logic                 lin_present,
    input  logic [DATA_W-1:0]    exp_cv,
    input  logic                 exp_present,
    input  logic                 last_channel,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [DATA_W-1:0]    channel_out,
    output logic [DATA_W-1:0]    mix_one,
    output logic [DATA_W-1:0]    mix_two,
    output logic                 mix_valid
);

    localparam int          Span   = EXP_TABLE_POINTS - 1;
    localparam int          IdxW   = $clog2(EXP_TABLE_POINTS);
    localparam logic [63:0] ExpDen = EXP_DEN_Q30;

    function automatic logic [15:0] exp_entry(input int k);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] ip;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] num;
        logic [63:0] e;
        x    = (64'(k) * ONE_Q30) / 64'(EXP_TABLE_POINTS - 1);
        y    = (x * LOG2_50_Q30) >> 30;
        ip   = y >> 30;
        t    = ((y & (ONE_Q30 - 64'd1)) * LN2_Q30) >> 30;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= EXP_SERIES_TERMS; n++)
        begin
            term = ((term * t) >> 30) / 64'(n);
            sum  = sum + term;
        end
        r   = sum << ip[2:0];
        num = (r - ONE_Q30) * Q15_ONE;
        e   = (num + ExpDen / 64'd2) / ExpDen;
        if (e > Q15_ONE)
            e = Q15_ONE;
        if (k == 0)
            e = 64'd0;
        if (k == Span)
            e = Q15_ONE;
        return e[15:0];
    endfunction

    function automatic logic [14:0] clamp_cv(input logic [15:0] cv);
        logic [14:0] v;
        if (cv[15])
            v = '0;
        else if (cv[14:0] > TEN_VOLTS)
            v = TEN_VOLTS;
        else
            v = cv[14:0];
        return v;
    endfunction

    function automatic logic [15:0] sat_sm(input logic neg, input logic [20:0] mag);
        logic [15:0] v;
        if (neg)
            v = (mag >= 21'd32768) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
        else
            v = (mag > 21'd32767) ? 16'h7FFF : mag[15:0];
        return v;
    endfunction

    logic [15:0] exp_tab [EXP_TABLE_POINTS];

    for (genvar k = 0; k < EXP_TABLE_POINTS; k++)
    begin : g_tab
        localparam logic [15:0] Entry = exp_entry(k);
        assign exp_tab[k] = Entry;
    end

    logic [15:0]       level_gain_reg;
    logic [15:0]       mix_one_gain_reg;
    logic [15:0]       mix_two_gain_reg;
    logic              s_neg_reg;
    logic [16:0]       s_mag_reg;
    logic [14:0]       lc_reg;
    logic [14:0]       xc_reg;
    logic              lin_on_reg;
    logic              exp_on_reg;
    logic              last_reg;
    logic [31:0]       m_reg;
    logic [47:0]       prod_reg;
    logic [IdxW-1:0]   idx_reg;
    logic [14:0]       frac_reg;
    logic [15:0]       ta_reg;
    logic [15:0]       tb_reg;
    logic [15:0]       g_reg;
    logic [15:0]       ch_reg;
    logic [MIX_W-1:0]  acc_reg;
    logic              acc_neg_reg;
    logic [MIX_W-1:0]  acc_mag_reg;
    logic [MIX_W-1:0]  mix_sum_reg;
    logic [15:0]       mix1_reg;
    logic [15:0]       mix2_reg;
    logic [15:0]       channel_out_reg;
    logic [15:0]       mix_one_reg;
    logic [15:0]       mix_two_reg;
    logic              mix_valid_reg;

    logic [31:0]       mul_a;
    logic [15:0]       mul_b;
    logic [15:0]       tab_diff;
    logic [47:0]       prod_rnd10;
    logic [47:0]       prod_rnd15;
    logic [DIV_W-1:0]  div_n;
    logic [DIV_W-1:0]  div_quo;
    logic [2:0]        div_rem;
    logic              div_done;
    logic [16:0]       s_ext;
    logic [32:0]       m_rnd;
    logic [MIX_W:0]    acc_sum;
    logic [MIX_W-1:0]  acc_sat;
    logic [IdxW-1:0]   idx_inc;
    logic [31:0]       m_next;

    assign tab_diff   = (tb_reg >= ta_reg) ? 16'(tb_reg - ta_reg) : 16'd0;
    assign prod_rnd10 = prod_reg + HALF_TEN;
    assign prod_rnd15 = prod_reg + ROUND_Q15;
    assign div_n      = cmd.div_round ? DIV_W'(prod_rnd10[47:12]) : DIV_W'(prod_reg[47:12]);
    assign s_ext      = {sample[15], sample};
    assign m_rnd      = {1'b0, m_reg} + 33'd16384;
    assign acc_sum    = {{(MIX_W + 1 - DATA_W){ch_reg[15]}}, ch_reg}
                      + {mix_sum_reg[MIX_W-1], mix_sum_reg};
    assign acc_sat    = (acc_sum[MIX_W] != acc_sum[MIX_W-1])
                      ? {acc_sum[MIX_W], {(MIX_W - 1){~acc_sum[MIX_W]}}}
                      : acc_sum[MIX_W-1:0];
    assign idx_inc    = idx_reg + IdxW'(1);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LEVEL:
            begin
                mul_a = 32'(s_mag_reg);
                mul_b = level_gain_reg;
            end
            MUL_LIN:
            begin
                mul_a = m_reg;
                mul_b = 16'(lc_reg);
            end
            MUL_POS:
            begin
                mul_a = 32'(xc_reg);
                mul_b = 16'(Span);
            end
            MUL_INTERP:
            begin
                mul_a = 32'(tab_diff);
                mul_b = 16'(frac_reg);
            end
            MUL_EXP:
            begin
                mul_a = m_reg;
                mul_b = g_reg;
            end
            MUL_MIX1:
            begin
                mul_a = 32'(acc_mag_reg);
                mul_b = mix_one_gain_reg;
            end
            MUL_MIX2:
            begin
                mul_a = 32'(acc_mag_reg);
                mul_b = mix_two_gain_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.m_src)
            M_SRC_LEVEL: m_next = prod_reg[31:0];
            M_SRC_DIV:   m_next = div_quo[31:0];
            M_SRC_EXP:   m_next = prod_rnd15[46:15];
            default:     m_next = m_reg;
        endcase
    end

    vca_div5 u_div5
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_n),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_gain_reg   <= GAIN_UNITY;
            mix_one_gain_reg <= GAIN_UNITY;
            mix_two_gain_reg <= GAIN_UNITY;
            mix_sum_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVEL:   level_gain_reg   <= cfg_wdata;
                    CFG_MIX_ONE: mix_one_gain_reg <= cfg_wdata;
                    CFG_MIX_TWO: mix_two_gain_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
            if (cmd.out_load)
                mix_sum_reg <= last_reg ? '0 : acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_neg_reg  <= sample[15];
            s_mag_reg  <= sample[15] ? 17'(~s_ext + 17'd1) : s_ext;
            lc_reg     <= clamp_cv(lin_cv);
            xc_reg     <= clamp_cv(exp_cv);
            lin_on_reg <= lin_present;
            exp_on_reg <= exp_present;
            last_reg   <= last_channel;
        end
        if (cmd.mul_en)
            prod_reg <= 48'(mul_a) * 48'(mul_b);
        if (cmd.m_wb)
            m_reg <= m_next;
        if (cmd.idx_wb)
        begin
            if (div_quo >= DIV_W'(Span))
            begin
                idx_reg  <= IdxW'(Span - 1);
                frac_reg <= TEN_VOLTS;
            end
            else
            begin
                idx_reg  <= div_quo[IdxW-1:0];
                frac_reg <= {div_rem, prod_reg[11:0]};
            end
        end
        if (cmd.tab_rd)
        begin
            ta_reg <= exp_tab[idx_reg];
            tb_reg <= exp_tab[idx_inc];
        end
        if (cmd.g_wb)
            g_reg <= 16'(ta_reg + div_quo[15:0]);
        if (cmd.ch_wb)
            ch_reg <= sat_sm(s_neg_reg, 21'(m_rnd[32:15]));
        if (cmd.acc_wb)
        begin
            acc_reg     <= acc_sat;
            acc_neg_reg <= acc_sat[MIX_W-1];
            acc_mag_reg <= acc_sat[MIX_W-1] ? MIX_W'(~acc_sat + MIX_W'(1)) : acc_sat;
        end
        if (cmd.mix1_wb)
            mix1_reg <= sat_sm(acc_neg_reg, prod_rnd15[35:15]);
        if (cmd.mix2_wb)
            mix2_reg <= sat_sm(acc_neg_reg, prod_rnd15[35:15]);
        if (cmd.out_load)
        begin
            channel_out_reg <= ch_reg;
            mix_one_reg     <= last_reg ? mix1_reg : '0;
            mix_two_reg     <= last_reg ? mix2_reg : '0;
            mix_valid_reg   <= last_reg;
        end
    end

    assign stat.lin_on   = lin_on_reg;
    assign stat.exp_on   = exp_on_reg;
    assign stat.last     = last_reg;
    assign stat.div_done = div_done;

    assign channel_out = channel_out_reg;
    assign mix_one     = mix_one_reg;
    assign mix_two     = mix_two_reg;
    assign mix_valid   = mix_valid_reg;

endmodule
`default_nettype wire

[rtl/core/vca_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_ctrl
// Sequencer for one channel transaction and the output register handshake.
// ----------------------------------------------------------------------------
module vca_ctrl import vca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_LEVEL    = 5'd1;
    localparam logic [4:0] ST_LEVEL_WB = 5'd2;
    localparam logic [4:0] ST_LIN_MUL  = 5'd3;
    localparam logic [4:0] ST_LIN_DIV0 = 5'd4;
    localparam logic [4:0] ST_LIN_DIV  = 5'd5;
    localparam logic [4:0] ST_POS_MUL  = 5'd6;
    localparam logic [4:0] ST_POS_DIV0 = 5'd7;
    localparam logic [4:0] ST_POS_DIV  = 5'd8;
    localparam logic [4:0] ST_TAB      = 5'd9;
    localparam logic [4:0] ST_INT_MUL  = 5'd10;
    localparam logic [4:0] ST_INT_DIV0 = 5'd11;
    localparam logic [4:0] ST_INT_DIV  = 5'd12;
    localparam logic [4:0] ST_EXP_MUL  = 5'd13;
    localparam logic [4:0] ST_EXP_WB   = 5'd14;
    localparam logic [4:0] ST_FIN      = 5'd15;
    localparam logic [4:0] ST_ACC      = 5'd16;
    localparam logic [4:0] ST_MIX1     = 5'd17;
    localparam logic [4:0] ST_MIX2     = 5'd18;
    localparam logic [4:0] ST_MIX2_WB  = 5'd19;
    localparam logic [4:0] ST_OUT      = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_sel  = MUL_LEVEL;
        cmd.m_src    = M_SRC_LEVEL;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LEVEL;
                state_next  = ST_LEVEL_WB;
            end
            ST_LEVEL_WB:
            begin
                cmd.m_wb  = 1'b1;
                cmd.m_src = M_SRC_LEVEL;
                if (stat.lin_on)
                    state_next = ST_LIN_MUL;
                else if (stat.exp_on)
                    state_next = ST_POS_MUL;
                else
                    state_next = ST_FIN;
            end
            ST_LIN_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LIN;
                state_next  = ST_LIN_DIV0;
            end
            ST_LIN_DIV0:
            begin
                cmd.div_start = 1'b1;
                cmd.div_round = 1'b1;
                state_next    = ST_LIN_DIV;
            end
            ST_LIN_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.m_wb   = 1'b1;
                    cmd.m_src  = M_SRC_DIV;
                    state_next = stat.exp_on ? ST_POS_MUL : ST_FIN;
                end
            end
            ST_POS_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_POS;
                state_next  = ST_POS_DIV0;
            end
            ST_POS_DIV0:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_POS_DIV;
            end
            ST_POS_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.idx_wb = 1'b1;
                    state_next = ST_TAB;
                end
            end
            ST_TAB:
            begin
                cmd.tab_rd = 1'b1;
                state_next = ST_INT_MUL;
            end
            ST_INT_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTERP;
                state_next  = ST_INT_DIV0;
            end
            ST_INT_DIV0:
            begin
                cmd.div_start = 1'b1;
                cmd.div_round = 1'b1;
                state_next    = ST_INT_DIV;
            end
            ST_INT_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.g_wb   = 1'b1;
                    state_next = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_EXP;
                state_next  = ST_EXP_WB;
            end
            ST_EXP_WB:
            begin
                cmd.m_wb   = 1'b1;
                cmd.m_src  = M_SRC_EXP;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.ch_wb  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_wb = 1'b1;
                state_next = stat.last ? ST_MIX1 : ST_OUT;
            end
            ST_MIX1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MIX1;
                state_next  = ST_MIX2;
            end
            ST_MIX2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MIX2;
                cmd.mix1_wb = 1'b1;
                state_next  = ST_MIX2_WB;
            end
            ST_MIX2_WB:
            begin
                cmd.mix2_wb = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

[rtl/core/vca_bank_with_mix.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_bank_with_mix
// Bank of voltage controlled amplifiers with linear and exponential control
// and a two-output mix bus summed over each frame.
// ----------------------------------------------------------------------------
//  port group | direction | handshake               | contents
//  s_axis     | in        | tvalid / tready         | channel sample, controls
//  m_axis     | out       | tvalid / tready         | channel and mix results
//  cfg        | in        | cfg_we, no back-pressure| level and mix gains
//
//  Transaction length grows with linear control and with exponential control
//  connected, and on the last channel of a frame. It is set by the single
//  shared 32x16 multiplier and the divide-by-five unit, which retires one
//  byte of dividend per cycle. Reset clears the sequencer, the output valid
//  and the mix sum, and sets the gains to unity. A full output register
//  holds the sequencer before its final load; input is taken again once
//  the result is in the output register.
// ----------------------------------------------------------------------------
module vca_bank_with_mix import vca_pkg::*;
#(
    parameter int EXP_TABLE_POINTS = EXP_TABLE_POINTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // sample, lin_cv, exp_cv
    input  logic [1:0]           s_axis_tuser,  // lin_present, exp_present
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,  // channel_out, mix_one, mix_two
    output logic [0:0]           m_axis_tuser,  // mix_valid
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [DATA_W-1:0] channel_out;
    logic [DATA_W-1:0] mix_one;
    logic [DATA_W-1:0] mix_two;
    logic              mix_valid;

    vca_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vca_dp #(.EXP_TABLE_POINTS(EXP_TABLE_POINTS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (s_axis_tdata[15:0]),
        .lin_cv       (s_axis_tdata[31:16]),
        .lin_present  (s_axis_tuser[0]),
        .exp_cv       (s_axis_tdata[47:32]),
        .exp_present  (s_axis_tuser[1]),
        .last_channel (s_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .channel_out  (channel_out),
        .mix_one      (mix_one),
        .mix_two      (mix_two),
        .mix_valid    (mix_valid)
    );

    assign m_axis_tdata = {mix_two, mix_one, channel_out};
    assign m_axis_tuser = mix_valid;

endmodule
`default_nettype wire

[rtl/core/vca_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_chk
// Port-level checks for vca_bank_with_mix, attached by bind.
// ----------------------------------------------------------------------------
`include "vca_bank_with_mix_macros.svh"

module vca_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    `VCA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `VCA_ASSERT_SAME(a_mix_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[47:16] == 32'd0, "mix fields set off frame end")
    `VCA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped")
    `VCA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed")

endmodule

bind vca_bank_with_mix vca_chk u_vca_chk (.*);
`default_nettype wire

[bench/vca_bank_with_mix_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vca_bank_with_mix_tb
// Drives channel transactions into the amplifier bank and checks every
// channel and mix result against an in-bench model or the listed values of
// typed directed rows. The model covers level, linear and exponential gain
// and the saturating frame sum. A directed table runs first. Random frames
// follow under several gain settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module vca_bank_with_mix_tb;
    import vca_pkg::*;

    localparam int EXP_POINTS      = 33;
    localparam int CHANNELS        = 8;
    localparam int STALL_LIMIT     = 1000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 173;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned LOG2_FIFTY = 64'd6060044440;
    localparam longint unsigned LN_TWO     = 64'd744261118;
    localparam longint unsigned FULL_CV    = 64'd20480;
    localparam longint          MIX_HI     = 524287;
    localparam longint          MIX_LO     = -524288;

    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] lin_cv;
        logic [15:0] exp_cv;
        logic        lin_on;
        logic        exp_on;
        logic        last_ch;
    } vca_item_t;

    typedef struct packed {
        logic [15:0] channel_out;
        logic [15:0] mix_one;
        logic [15:0] mix_two;
        logic        mix_valid;
    } vca_result_t;

    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] lin_cv;
        logic        lin_on;
        logic [15:0] exp_cv;
        logic        exp_on;
        logic        last_ch;
        logic        typed;
        logic [15:0] ch;
        logic [15:0] mix1;
        logic [15:0] mix2;
        logic        mixv;
    } stim_row_t;

    // sample, lin_cv, lin_on, exp_cv, exp_on, last, typed, channel, mix1, mix2, valid
    localparam stim_row_t DIRECTED [21] = '{
        '{16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 1'b1},
        '{16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1,
          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1},
        '{16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1,
          16'h8000, 16'h8000, 16'h8000, 1'b1},
        '{16'h7FFF, 16'h8000, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1,
          16'h7FFF, 16'h0000, 16'h0000, 1'b0},
        '{16'h8000, 16'h0000, 1'b0, 16'h8000, 1'b1, 1'b0, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h0000, 1'b0, 16'h7FFF, 1'b1, 1'b1, 1'b1,
          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1},
        '{16'd12345, 16'd20480, 1'b1, 16'd20480, 1'b1, 1'b0, 1'b1,
          16'd12345, 16'h0000, 16'h0000, 1'b0},
        '{-16'sd12345, 16'd20480, 1'b1, 16'd20480, 1'b1, 1'b1, 1'b1,
          -16'sd12345, 16'h0000, 16'h0000, 1'b1},
        '{16'd1000, 16'd10240, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'hFFFF, 16'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'd20000, 16'd20479, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'd30000, 16'h0000, 1'b0, 16'd1, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{-16'sd30000, 16'h0000, 1'b0, 16'd640, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'd25000, 16'h0000, 1'b0, 16'd10240, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{-16'sd25000, 16'h0000, 1'b0, 16'd20479, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'd16384, 16'd20481, 1'b1, 16'd20481, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{-16'sd7, 16'd15000, 1'b1, 16'd9000, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'h7FFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0},
        '{16'h8000, 16'd5000, 1'b1, 16'd17000, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0},
        '{16'd5555, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b0}
    };

    localparam logic [15:0] CV_EDGES [8] = '{
        16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
        16'd20479, 16'd20480, 16'd20481, 16'h7FFF
    };
    localparam logic [15:0] SAMPLE_EDGES [5] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;   // sample, lin_cv, exp_cv
    logic [1:0]           s_axis_tuser = '0;   // lin_present, exp_present
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;        // channel_out, mix_one, mix_two
    logic [0:0]           m_axis_tuser;        // mix_valid
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_wdata = '0;

    logic                 calm = 1'b0;
    int                   mismatch_count = 0;
    int                   idle_cycles = 0;

    longint unsigned      exp_lut [EXP_POINTS];
    logic [15:0]          gain_level = 16'd32768;
    logic [15:0]          gain_mix_one = 16'd32768;
    logic [15:0]          gain_mix_two = 16'd32768;
    longint               mix_total = 0;
    vca_result_t          expected_outputs [$];

    vca_bank_with_mix #(
        .EXP_TABLE_POINTS (EXP_POINTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void build_exp_lut();
        longint unsigned x, y, ip, t, acc, term, r, num, den, e;
        for (int k = 0; k < EXP_POINTS; k++)
        begin
            x = (longint'(k) * Q30_ONE) / (EXP_POINTS - 1);
            y = (x * LOG2_FIFTY) >> 30;
            ip = y >> 30;
            t = ((y & (Q30_ONE - 1)) * LN_TWO) >> 30;
            acc = Q30_ONE;
            term = Q30_ONE;
            for (int n = 1; n <= 14; n++)
            begin
                term = ((term * t) >> 30) / n;
                acc += term;
            end
            r = acc << (ip & 7);
            den = 64'd49 << 30;
            num = (r - Q30_ONE) * 32768;
            e = (num + den / 2) / den;
            if (e > 32768)
                e = 32768;
            exp_lut[k] = e;
        end
        exp_lut[0] = 0;
        exp_lut[EXP_POINTS - 1] = 32768;
    endfunction

    function automatic longint unsigned clamp_cv(logic [15:0] cv);
        if ($signed(cv) < 0)
            return 0;
        else if ($signed(cv) > 20480)
            return FULL_CV;
        else
            return longint'(cv);
    endfunction

    function automatic longint unsigned exp_gain_q15(logic [15:0] cv);
        longint unsigned pos, idx, frac, a, b, d;
        pos = clamp_cv(cv) * (EXP_POINTS - 1);
        idx = pos / FULL_CV;
        frac = pos % FULL_CV;
        if (idx >= EXP_POINTS - 1)
        begin
            idx = EXP_POINTS - 2;
            frac = FULL_CV;
        end
        a = exp_lut[idx];
        b = exp_lut[idx + 1];
        d = (b >= a) ? b - a : 0;
        return a + (d * frac + FULL_CV / 2) / FULL_CV;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        else if (v < -32768)
            return 16'h8000;
        else
            return 16'(v);
    endfunction

    function automatic logic [15:0] scale_q15(longint v, longint unsigned g);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m * g + 16384) >> 15;
        return clip16((v < 0) ? -longint'(m) : longint'(m));
    endfunction

    function automatic vca_result_t amplify_and_mix(vca_item_t it);
        longint          sv, total;
        longint unsigned mag;
        logic            neg;
        vca_result_t     res;
        sv = $signed(it.sample);
        neg = sv < 0;
        mag = neg ? longint'(-sv) : longint'(sv);
        mag = mag * gain_level;
        if (it.lin_on)
            mag = (mag * clamp_cv(it.lin_cv) + FULL_CV / 2) / FULL_CV;
        if (it.exp_on)
            mag = (mag * exp_gain_q15(it.exp_cv) + 16384) >> 15;
        mag = (mag + 16384) >> 15;
        res.channel_out = clip16(neg ? -longint'(mag) : longint'(mag));
        total = mix_total + longint'($signed(res.channel_out));
        if (total > MIX_HI)
            total = MIX_HI;
        if (total < MIX_LO)
            total = MIX_LO;
        if (it.last_ch)
        begin
            res.mix_one = scale_q15(total, gain_mix_one);
            res.mix_two = scale_q15(total, gain_mix_two);
            res.mix_valid = 1'b1;
            mix_total = 0;
        end
        else
        begin
            res.mix_one = '0;
            res.mix_two = '0;
            res.mix_valid = 1'b0;
            mix_total = total;
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_cv();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(0, 20480));
            default: return CV_EDGES[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'd65535;
            3:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic vca_item_t random_channel(logic last_ch, logic loud, logic loud_neg);
        vca_item_t   it;
        logic [15:0] mag;
        if (loud)
        begin
            mag = 16'($urandom_range(16384, 32767));
            it.sample = loud_neg ? -mag : mag;
            it.lin_on = 1'b0;
            it.exp_on = 1'b0;
        end
        else
        begin
            it.sample = ($urandom_range(0, 7) == 0) ? SAMPLE_EDGES[$urandom_range(0, 4)]
                                                    : 16'($urandom);
            it.lin_on = $urandom_range(0, 4) < 3;
            it.exp_on = $urandom_range(0, 4) < 3;
        end
        it.lin_cv = pick_cv();
        it.exp_cv = pick_cv();
        it.last_ch = last_ch;
        return it;
    endfunction

    task automatic issue(input vca_item_t it, input logic typed, input vca_result_t known);
        vca_result_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tdata  <= {it.exp_cv, it.lin_cv, it.sample};
        s_axis_tuser  <= {it.exp_on, it.lin_on};
        s_axis_tlast  <= it.last_ch;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = amplify_and_mix(it);
        expected_outputs.push_back(typed ? known : predicted);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_LEVEL:   gain_level = value;
            CFG_MIX_ONE: gain_mix_one = value;
            CFG_MIX_TWO: gain_mix_two = value;
            default:     ;
        endcase
    endtask

    task automatic program_gains(input logic [15:0] lvl, input logic [15:0] g1,
                                 input logic [15:0] g2);
        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_LEVEL, lvl);
        write_reg(CFG_MIX_ONE, g1);
        write_reg(CFG_MIX_TWO, g2);
        cfg_we <= 1'b0;
    endtask

    // hold ready in random runs, drop it in bursts until the final phase
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        vca_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("result with no transaction pending: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (m_axis_tdata[15:0] !== want.channel_out)
                begin
                    $error("channel_out: expected %0d, got %0d",
                           $signed(want.channel_out), $signed(m_axis_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[31:16] !== want.mix_one)
                begin
                    $error("mix_one: expected %0d, got %0d",
                           $signed(want.mix_one), $signed(m_axis_tdata[31:16]));
                    mismatch_count++;
                end
                if (m_axis_tdata[47:32] !== want.mix_two)
                begin
                    $error("mix_two: expected %0d, got %0d",
                           $signed(want.mix_two), $signed(m_axis_tdata[47:32]));
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.mix_valid)
                begin
                    $error("mix_valid: expected %0d, got %0d", want.mix_valid, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("vca_bank_with_mix_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t   row;
        vca_item_t   it;
        vca_result_t known;
        int          sent;
        int          len;
        logic        loud;
        logic        loud_neg;

        build_exp_lut();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            it.sample = row.sample;
            it.lin_cv = row.lin_cv;
            it.lin_on = row.lin_on;
            it.exp_cv = row.exp_cv;
            it.exp_on = row.exp_on;
            it.last_ch = row.last_ch;
            known.channel_out = row.ch;
            known.mix_one = row.mix1;
            known.mix_two = row.mix2;
            known.mix_valid = row.mixv;
            issue(it, row.typed, known);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            calm = (phase == NUM_PHASES - 1);
            case (phase)
                0:       program_gains(16'd32768, 16'd0, 16'd0);
                1:       program_gains(16'd65535, 16'd65535, 16'd65535);
                2:       program_gains(16'd0, 16'd32768, 16'd65535);
                default: program_gains(pick_gain(), pick_gain(), pick_gain());
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(CHANNELS + 1, 24)
                                                  : $urandom_range(1, CHANNELS);
                loud = $urandom_range(0, 5) == 0;
                loud_neg = $urandom_range(0, 1);
                for (int c = 0; c < len; c++)
                    issue(random_channel(c == len - 1, loud, loud_neg), 1'b0, known);
                sent += len;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (expected_outputs.size() != 0)
        begin
            $error("%0d results never arrived", expected_outputs.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("vca_bank_with_mix_tb: PASS");
        else
            $display("vca_bank_with_mix_tb: FAIL");
        $finish;
    end

endmodule
